// File: design/iois_pkg.sv
// Package for the insertion-ordered integer set.
// Holds the capacity, operation codes and the word and cell control types.
// Used by every module of the block.
package iois_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_CONTAINS = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic       ok;
        logic [5:0] count;
    } t_out_word;

    typedef struct packed {
        logic [31:0] key;
        logic        cmp;
        logic        write;
        logic        shift;
    } t_cell_ctrl;

endpackage

// File: design/iois_cell.sv
// One slot of the member row: a stored value and its registered key match.
// Depends on iois_pkg for the cell control type.
module iois_cell
    import iois_pkg::*;
(
    input  logic        i_clk,
    input  t_cell_ctrl  i_ctrl,
    input  logic        i_occupied,
    input  logic        i_tail,
    input  logic [31:0] i_next_value,
    input  logic        i_seen,
    output logic [31:0] o_value,
    output logic        o_seen
);

    logic [31:0] r_value;
    logic        r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_match <= i_occupied && (r_value == i_ctrl.key);
        end
        if (i_ctrl.write && i_tail) begin
            r_value <= i_ctrl.key;
        end else if (i_ctrl.shift && o_seen) begin
            r_value <= i_next_value;
        end
    end

    assign o_seen  = i_seen | r_match;
    assign o_value = r_value;

endmodule

// File: design/insertion_ordered_int_set.sv
// Insertion-ordered set of distinct 32-bit integers built from a row of cells.
// An accepted word passes through a compare step, then a commit step, before its result is registered.
// A new word is accepted only in the idle state, once the previous word has committed.
// A stalled result holds the commit step until the output register is free.
// Reset is synchronous and active low; it empties the set and drops all valids.
// Stored values are not cleared; slots at or above the count never report a match.
module insertion_ordered_int_set
    import iois_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CMP    = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_kind;
    logic [31:0]      r_key;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_out_word        r_out_word;

    t_cell_ctrl       cell_ctrl;
    logic [31:0]      cell_value [CAPACITY];
    logic [31:0]      cell_next  [CAPACITY];
    logic [CAPACITY:0] seen_chain;
    logic             found, full, commit, ok;

    assign seen_chain[0] = 1'b0;
    assign found         = seen_chain[CAPACITY];
    assign full          = (r_count == CNT_W'(CAPACITY));
    assign commit        = (r_state == ST_COMMIT) && (!r_out_valid || i_out_ready);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == CAPACITY - 1) begin : g_last
                assign cell_next[g] = cell_value[g];
            end else begin : g_mid
                assign cell_next[g] = cell_value[g + 1];
            end
            iois_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (cell_ctrl),
                .i_occupied   (CNT_W'(g) < r_count),
                .i_tail       (CNT_W'(g) == r_count),
                .i_next_value (cell_next[g]),
                .i_seen       (seen_chain[g]),
                .o_value      (cell_value[g]),
                .o_seen       (seen_chain[g + 1])
            );
        end
    endgenerate

    always_comb begin
        ok      = 1'b0;
        n_count = r_count;
        cell_ctrl.key   = r_key;
        cell_ctrl.cmp   = (r_state == ST_CMP);
        cell_ctrl.write = 1'b0;
        cell_ctrl.shift = 1'b0;
        case (r_kind)
            OP_ADD: begin
                ok = !full && !found;
                if (ok) begin
                    n_count = r_count + CNT_W'(1);
                end
                cell_ctrl.write = commit && ok;
            end
            OP_REMOVE: begin
                ok = found;
                if (ok) begin
                    n_count = r_count - CNT_W'(1);
                end
                cell_ctrl.shift = commit && ok;
            end
            OP_CONTAINS: begin
                ok = found;
            end
            OP_CLEAR: begin
                ok      = 1'b1;
                n_count = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_kind <= i_in_word.kind;
            r_key  <= i_in_word.value;
        end
        if (commit) begin
            r_out_word.ok    <= ok;
            r_out_word.count <= 6'(n_count);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: design/iois_check.sv
// Port-level checker for the insertion-ordered integer set, with its bind.
// Depends on iois_pkg for the word types and the capacity.
module iois_check
    import iois_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_word.count) <= 32'(CAPACITY)))
        else $error("count above capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word accepted during an operation");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without an accepted word");

endmodule

bind insertion_ordered_int_set iois_check u_iois_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// File: bench/insertion_ordered_int_set_test.sv
// Testbench for the insertion-ordered integer set: directed, full-set and random words.
// Every accepted word is predicted by a local copy of the set and compared on return.
// Depends on iois_pkg and insertion_ordered_int_set.
module insertion_ordered_int_set_test
    import iois_pkg::*;
;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    logic [31:0] held_values [CAPACITY];
    int          held_count = 0;
    t_out_word   predicted_replies [$];
    int          mismatch_count = 0;
    bit          sender_idles = 1'b0;
    bit          receiver_stalls = 1'b0;
    int          ready_run = 0;
    logic [31:0] value_pool [40];

    insertion_ordered_int_set DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out_word apply_set_op(t_in_word w);
        int        slot = -1;
        t_out_word r;
        for (int i = 0; i < held_count; i++) begin
            if (slot < 0 && held_values[i] == w.value) begin
                slot = i;
            end
        end
        r.ok = 1'b0;
        case (w.kind)
            OP_ADD: begin
                if (held_count < CAPACITY && slot < 0) begin
                    held_values[held_count] = w.value;
                    held_count++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (slot >= 0) begin
                    for (int i = slot; i < held_count - 1; i++) begin
                        held_values[i] = held_values[i + 1];
                    end
                    held_count--;
                    r.ok = 1'b1;
                end
            end
            OP_CONTAINS: begin
                r.ok = (slot >= 0);
            end
            OP_CLEAR: begin
                held_count = 0;
                r.ok = 1'b1;
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        r.count = held_count[5:0];
        return r;
    endfunction

    function automatic void report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    task automatic check_reply(t_out_word got);
        t_out_word want;
        if (predicted_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected word ok=%0b count=%0d", got.ok, got.count));
        end else begin
            want = predicted_replies.pop_front();
            if (got.ok !== want.ok || got.count !== want.count) begin
                report_mismatch($sformatf("expected ok=%0b count=%0d, got ok=%0b count=%0d",
                                          want.ok, want.count, got.ok, got.count));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predicted_replies.push_back(apply_set_op(i_in_word));
            end
            if (o_out_valid && i_out_ready) begin
                check_reply(o_out_word);
            end
        end
    end

    function automatic int idle_cycles();
        int r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 94) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    always @(posedge i_clk) begin
        if (!receiver_stalls) begin
            i_out_ready <= 1'b1;
        end else if (ready_run == 0) begin
            if (i_out_ready) begin
                i_out_ready <= 1'b0;
                ready_run = idle_cycles() - 1;
            end else begin
                i_out_ready <= 1'b1;
                ready_run = $urandom_range(0, 12);
            end
        end else begin
            ready_run--;
        end
    end

    task automatic send_word(logic [1:0] kind, logic [31:0] value);
        int gap;
        gap = (sender_idles && $urandom_range(0, 1)) ? idle_cycles() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= {kind, value};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        int r = $urandom_range(0, 99);
        if (r < 75) begin
            return value_pool[$urandom_range(0, 39)];
        end else if (r < 85) begin
            return value_pool[$urandom_range(0, 39)] ^ (32'h1 << $urandom_range(0, 31));
        end
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_kind();
        int r = $urandom_range(0, 99);
        if (r < 42) begin
            return OP_ADD;
        end else if (r < 66) begin
            return OP_REMOVE;
        end else if (r < 99) begin
            return OP_CONTAINS;
        end
        return OP_CLEAR;
    endfunction

    task automatic test_directed();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        send_word(OP_CONTAINS, 32'h0000_0000);
        send_word(OP_REMOVE,   32'h8000_0000);
        send_word(OP_ADD,      32'h8000_0000);
        send_word(OP_ADD,      32'h7FFF_FFFF);
        send_word(OP_ADD,      32'h0000_0000);
        send_word(OP_ADD,      32'hFFFF_FFFF);
        send_word(OP_ADD,      32'h7FFF_FFFF);
        send_word(OP_CONTAINS, 32'h8000_0000);
        send_word(OP_CONTAINS, 32'h8000_0001);
        send_word(OP_CONTAINS, 32'hFFFF_FFFF);
        send_word(OP_REMOVE,   32'h8000_0000);
        send_word(OP_CONTAINS, 32'h7FFF_FFFF);
        send_word(OP_REMOVE,   32'hFFFF_FFFF);
        send_word(OP_REMOVE,   32'hFFFF_FFFF);
        send_word(OP_CONTAINS, 32'h0000_0000);
        send_word(OP_ADD,      32'h8000_0000);
        send_word(OP_CLEAR,    32'hFFFF_FFFF);
        send_word(OP_CONTAINS, 32'h0000_0000);
        send_word(OP_ADD,      32'h5555_5555);
        send_word(OP_ADD,      32'hAAAA_AAAA);
        send_word(OP_CLEAR,    32'h0000_0000);
        wait_for_replies();
    endtask

    task automatic test_full_set();
        logic [31:0] first_value;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        repeat (3) begin
            send_word(OP_CLEAR, $urandom());
            first_value = $urandom();
            send_word(OP_ADD, first_value);
            repeat (CAPACITY + 2) send_word(OP_ADD, $urandom());
            send_word(OP_ADD, first_value);
            send_word(OP_CONTAINS, first_value);
            repeat (4) send_word(OP_REMOVE, held_count > 0 ?
                                 held_values[$urandom_range(0, held_count - 1)] : $urandom());
            repeat (6) send_word(OP_ADD, $urandom());
            repeat (4) send_word(OP_CONTAINS, pick_value());
        end
    endtask

    task automatic test_random_ops(int n, bit idles, bit stalls);
        sender_idles    = idles;
        receiver_stalls = stalls;
        repeat (n) send_word(pick_kind(), pick_value());
    endtask

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 40; i++) begin
            value_pool[i] = $urandom();
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_set();
        test_random_ops(250, 1'b0, 1'b0);
        test_random_ops(550, 1'b1, 1'b1);
        wait_for_replies();
        test_random_ops(250, 1'b0, 1'b1);
        test_random_ops(500, 1'b1, 1'b0);

        wait_for_replies();
        repeat (20) @(posedge i_clk);
        if (predicted_replies.size() != 0) begin
            report_mismatch($sformatf("%0d words never returned", predicted_replies.size()));
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
